[rtl/tmtw_pkg.sv]
// ----------------------------------------------------------------------------
// tmtw_pkg
// Shared types and constants of the text-mode terminal writer: default
// screen size, cell encoding, item modes and controller states.
// ----------------------------------------------------------------------------
package tmtw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Cell encoding: attribute in the high byte, character in the low byte
    localparam logic [3:0] COLOR_BLACK      = 4'd0;
    localparam logic [3:0] COLOR_LIGHT_GREY = 4'd7;
    localparam logic [7:0] CHAR_SPACE       = 8'h20;
    localparam logic [7:0] NEWLINE_CODE     = 8'd10;
    localparam logic [7:0] ATTR_RESET       = {COLOR_BLACK, COLOR_LIGHT_GREY};
    localparam logic [15:0] BLANK_CELL      = {COLOR_BLACK, COLOR_LIGHT_GREY, CHAR_SPACE};

    // Item modes
    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_READ  = 2'd2
    } t_mode;

    // Controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUT,
        ST_COPY,
        ST_BLANK,
        ST_CLEAR,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

[rtl/tmtw_ram.sv]
// ----------------------------------------------------------------------------
// tmtw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tmtw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/tmtw_ctrl.sv]
// ----------------------------------------------------------------------------
// tmtw_ctrl
// Sequencer of the terminal writer: cursor registers, item decode, cell
// writes, scroll copy, blank and clear sweeps, and the result register.
// ----------------------------------------------------------------------------
module tmtw_ctrl
    import tmtw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    localparam int CELLS  = ROWS * COLUMNS,
    localparam int IDX_W  = $clog2(CELLS),
    localparam int ROW_W  = $clog2(ROWS + 1),
    localparam int COL_W  = $clog2(COLUMNS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // item channel
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_mode,
    input  logic [7:0]       i_char_code,
    input  logic [IDX_W-1:0] i_read_index,
    input  logic [7:0]       i_color_attr,
    // cell store
    output logic             o_ram_we,
    output logic [IDX_W-1:0] o_ram_waddr,
    output logic [15:0]      o_ram_wdata,
    output logic [IDX_W-1:0] o_ram_raddr,
    input  logic [15:0]      i_ram_rdata,
    // result channel
    output logic             o_strobe,
    output logic [IDX_W-1:0] o_written_index,
    output logic             o_wrote_cell,
    output logic             o_scrolled,
    output logic [ROW_W-1:0] o_cursor_row,
    output logic [COL_W-1:0] o_cursor_column,
    output logic [15:0]      o_read_data
);

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CELLS - 1);
    localparam logic [IDX_W-1:0] COPY_LAST = IDX_W'((ROWS - 1) * COLUMNS - 1);
    localparam logic [IDX_W-1:0] ROW_STEP  = IDX_W'(COLUMNS);
    localparam logic [ROW_W-1:0] ROW_PEND  = ROW_W'(ROWS);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);

    t_state           r_state, n_state;
    logic [1:0]       r_mode, n_mode;
    logic [7:0]       r_code, n_code;
    logic [IDX_W-1:0] r_ridx, n_ridx;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [IDX_W-1:0] r_ptr, n_ptr;
    logic             r_ret, n_ret;
    logic             r_scrolled, n_scrolled;
    logic [IDX_W-1:0] r_widx, n_widx;
    logic             r_wrote, n_wrote;
    // write stage: registered to line up with the registered read data in a copy
    logic             r_we, n_we;
    logic [IDX_W-1:0] r_waddr, n_waddr;
    logic             r_wsrc, n_wsrc;
    logic [15:0]      r_wdata, n_wdata;
    // result register
    logic             r_strobe, n_strobe;
    logic [IDX_W-1:0] r_o_widx, n_o_widx;
    logic             r_o_wrote, n_o_wrote;
    logic             r_o_scr, n_o_scr;
    logic [ROW_W-1:0] r_o_row, n_o_row;
    logic [COL_W-1:0] r_o_col, n_o_col;
    logic [15:0]      r_o_rdata, n_o_rdata;

    logic [IDX_W-1:0] cur_idx;
    logic             read_in_range;
    logic             accept;

    assign accept        = start && (r_state == ST_IDLE);
    assign cur_idx       = IDX_W'(r_row) * ROW_STEP + IDX_W'(r_col);
    assign read_in_range = {1'b0, r_ridx} < (IDX_W + 1)'(CELLS);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (r_ptr == LAST_IDX) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    case (i_mode)
                        MODE_PUT:   n_state = ST_PUT;
                        MODE_CLEAR: n_state = ST_CLEAR;
                        MODE_READ:  n_state = ST_READ;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_PUT: begin
                if (r_row == ROW_PEND) begin
                    n_state = ST_COPY;
                end else if (r_code == NEWLINE_CODE && r_row == ROW_LAST) begin
                    n_state = ST_COPY;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_COPY: begin
                if (r_ptr == COPY_LAST) n_state = ST_BLANK;
            end
            ST_BLANK: begin
                if (r_ptr == LAST_IDX) n_state = r_ret ? ST_PUT : ST_DONE;
            end
            ST_CLEAR: begin
                if (r_ptr == LAST_IDX) n_state = ST_DONE;
            end
            ST_READ:  n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_INIT;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_mode     = r_mode;
        n_code     = r_code;
        n_ridx     = r_ridx;
        n_row      = r_row;
        n_col      = r_col;
        n_ptr      = r_ptr;
        n_ret      = r_ret;
        n_scrolled = r_scrolled;
        n_widx     = r_widx;
        n_wrote    = r_wrote;
        n_we       = 1'b0;
        n_waddr    = r_ptr;
        n_wsrc     = 1'b0;
        n_wdata    = BLANK_CELL;
        n_strobe   = 1'b0;
        n_o_widx   = r_o_widx;
        n_o_wrote  = r_o_wrote;
        n_o_scr    = r_o_scr;
        n_o_row    = r_o_row;
        n_o_col    = r_o_col;
        n_o_rdata  = r_o_rdata;
        unique case (r_state)
            ST_INIT, ST_CLEAR: begin
                // sweep blanks over the whole store
                n_we  = 1'b1;
                n_ptr = r_ptr + 1'b1;
            end
            ST_IDLE: begin
                // latch the item
                if (accept) begin
                    n_mode     = i_mode;
                    n_code     = i_char_code;
                    n_ridx     = i_read_index;
                    n_ptr      = '0;
                    n_scrolled = 1'b0;
                    n_widx     = '0;
                    n_wrote    = 1'b0;
                end
            end
            ST_PUT: begin
                if (r_row == ROW_PEND) begin
                    // pending row: scroll first, then redo the put
                    n_ptr = '0;
                    n_ret = 1'b1;
                end else if (r_code == NEWLINE_CODE) begin
                    n_col = '0;
                    n_ptr = '0;
                    n_ret = 1'b0;
                    if (r_row != ROW_LAST) n_row = r_row + 1'b1;
                end else begin
                    // store the cell and advance the cursor
                    n_we    = 1'b1;
                    n_waddr = cur_idx;
                    n_wdata = {i_color_attr, r_code};
                    n_widx  = cur_idx;
                    n_wrote = 1'b1;
                    if (r_col == COL_LAST) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            ST_COPY: begin
                // move each cell up one row, read one row ahead
                n_we    = 1'b1;
                n_wsrc  = 1'b1;
                n_ptr   = r_ptr + 1'b1;
            end
            ST_BLANK: begin
                // blank the last row
                n_we  = 1'b1;
                n_ptr = r_ptr + 1'b1;
                if (r_ptr == LAST_IDX) begin
                    n_row      = ROW_LAST;
                    n_scrolled = 1'b1;
                    n_ptr      = '0;
                end
            end
            ST_READ: begin
                n_ptr = r_ptr;
            end
            ST_DONE: begin
                // load the result
                n_strobe  = 1'b1;
                n_o_widx  = r_widx;
                n_o_wrote = r_wrote;
                n_o_scr   = r_scrolled;
                n_o_row   = r_row;
                n_o_col   = r_col;
                n_o_rdata = (r_mode == MODE_READ && read_in_range) ? i_ram_rdata : '0;
            end
            default: begin
                n_ptr = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_ptr    <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_we     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_row    <= n_row;
            r_col    <= n_col;
            r_we     <= n_we;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_code     <= n_code;
        r_ridx     <= n_ridx;
        r_ret      <= n_ret;
        r_scrolled <= n_scrolled;
        r_widx     <= n_widx;
        r_wrote    <= n_wrote;
        r_waddr    <= n_waddr;
        r_wsrc     <= n_wsrc;
        r_wdata    <= n_wdata;
        r_o_widx   <= n_o_widx;
        r_o_wrote  <= n_o_wrote;
        r_o_scr    <= n_o_scr;
        r_o_row    <= n_o_row;
        r_o_col    <= n_o_col;
        r_o_rdata  <= n_o_rdata;
    end

    // Memory ports
    assign o_ram_we    = r_we;
    assign o_ram_waddr = r_waddr;
    assign o_ram_wdata = r_wsrc ? i_ram_rdata : r_wdata;
    assign o_ram_raddr = (r_state == ST_READ) ? r_ridx : (r_ptr + ROW_STEP);

    assign busy            = (r_state != ST_IDLE);
    assign o_strobe        = r_strobe;
    assign o_written_index = r_o_widx;
    assign o_wrote_cell    = r_o_wrote;
    assign o_scrolled      = r_o_scr;
    assign o_cursor_row    = r_o_row;
    assign o_cursor_column = r_o_col;
    assign o_read_data     = r_o_rdata;

endmodule

[rtl/text_mode_terminal_writer.sv]
// ----------------------------------------------------------------------------
// text_mode_terminal_writer
// Text-mode terminal engine: ROWS x COLUMNS store of character cells with a
// cursor, line wrap, scroll up and clear.
//
// Usage:
//   Items enter on start while busy is low: mode, char_code, read_index.
//   Mode 0 puts a character (10 is newline), mode 1 clears the screen,
//   mode 2 reads one cell. Every item yields one result, shown for exactly
//   one cycle with o_strobe high; the receiver cannot stall it.
//   The attribute register is written with i_cfg_wr_en / i_cfg_wr_data.
// Operation:
//   The result cycle may accept the next item. A scroll copies one cell a
//   cycle through the single read and write port, then blanks the last
//   row, and redoes the put when it scrolls a pending row; a newline on a
//   pending row scrolls twice.
// Reset:
//   Cursor goes to 0,0, attribute to light grey on black, and busy stays
//   high while the store is filled with blanks.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer
    import tmtw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    localparam int CELLS  = ROWS * COLUMNS,
    localparam int IDX_W  = $clog2(CELLS),
    localparam int ROW_W  = $clog2(ROWS + 1),
    localparam int COL_W  = $clog2(COLUMNS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_mode,
    input  logic [7:0]       i_char_code,
    input  logic [IDX_W-1:0] i_read_index,
    output logic             o_strobe,
    output logic [IDX_W-1:0] o_written_index,
    output logic             o_wrote_cell,
    output logic             o_scrolled,
    output logic [ROW_W-1:0] o_cursor_row,
    output logic [COL_W-1:0] o_cursor_column,
    output logic [15:0]      o_read_data
);

    logic [7:0]       r_color_attr;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [15:0]      ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [15:0]      ram_rdata;

    // Attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_attr <= ATTR_RESET;
        end else if (i_cfg_wr_en) begin
            r_color_attr <= i_cfg_wr_data;
        end
    end

    tmtw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tmtw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_char_code     (i_char_code),
        .i_read_index    (i_read_index),
        .i_color_attr    (r_color_attr),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wdata     (ram_wdata),
        .o_ram_raddr     (ram_raddr),
        .i_ram_rdata     (ram_rdata),
        .o_strobe        (o_strobe),
        .o_written_index (o_written_index),
        .o_wrote_cell    (o_wrote_cell),
        .o_scrolled      (o_scrolled),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_column (o_cursor_column),
        .o_read_data     (o_read_data)
    );

    // An accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // Results are never back to back
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results in consecutive cycles");

    // Reported cursor stays on screen or on the pending row
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ({1'b0, o_cursor_column} < (COL_W + 1)'(COLUMNS)
                      && o_cursor_row <= ROW_W'(ROWS)))
        else $error("cursor out of range");

    // No written index without a stored cell
    a_widx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_wrote_cell) |-> (o_written_index == '0))
        else $error("written index set without a write");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text-mode terminal writer. A queue of planned
// items (puts, newlines, clears, reads, spare-mode items and attribute writes)
// feeds a clocked driver; a clocked monitor checks every result strobe
// against a screen model that tracks cells, cursor, wrap, pending row,
// scroll and clear.
// ----------------------------------------------------------------------------
module tb;
    import tmtw_pkg::*;

    localparam int COLUMNS = DEF_COLUMNS;
    localparam int ROWS    = DEF_ROWS;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int IDX_W   = $clog2(CELLS);
    localparam int ROW_W   = $clog2(ROWS + 1);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int IDX_MAX = (1 << IDX_W) - 1;

    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int RAND_PHASES     = 5;
    localparam int ITEMS_PER_PHASE = 240;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PRINT_LIMIT     = 40;
    // double scroll on a pending row is the longest quiet stretch
    localparam int STALL_LIMIT     = 4 * (2 * CELLS + 16);

    typedef struct packed {
        logic             is_cfg;
        logic [7:0]       cfg_value;
        logic [7:0]       gap_pct;
        logic [1:0]       mode;
        logic [7:0]       code;
        logic [IDX_W-1:0] idx;
    } term_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] w_index;
        logic             wrote;
        logic             scrolled;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [15:0]      rdata;
    } term_result_t;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_wr_en   = 1'b0;
    logic [7:0]       i_cfg_wr_data = 8'h00;
    logic             start         = 1'b0;
    logic             busy;
    logic [1:0]       i_mode        = 2'd0;
    logic [7:0]       i_char_code   = 8'h00;
    logic [IDX_W-1:0] i_read_index  = '0;
    logic             o_strobe;
    logic [IDX_W-1:0] o_written_index;
    logic             o_wrote_cell;
    logic             o_scrolled;
    logic [ROW_W-1:0] o_cursor_row;
    logic [COL_W-1:0] o_cursor_column;
    logic [15:0]      o_read_data;

    // Screen model
    logic [15:0]      screen_model [CELLS];
    logic [ROW_W-1:0] row_model;
    logic [COL_W-1:0] col_model;
    logic [7:0]       attr_model;

    term_item_t   item_plan[$];
    term_result_t cell_expect[$];
    term_item_t   cur_item;

    int gap_pct_now;
    int gap_left;
    int idle_run;
    int gen_col;
    int mismatch_count;
    int items_sent;
    int put_count;
    int read_count;
    int clear_count;
    int scroll_count;
    int result_count;
    int stall_count;

    text_mode_terminal_writer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_char_code     (i_char_code),
        .i_read_index    (i_read_index),
        .o_strobe        (o_strobe),
        .o_written_index (o_written_index),
        .o_wrote_cell    (o_wrote_cell),
        .o_scrolled      (o_scrolled),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_column (o_cursor_column),
        .o_read_data     (o_read_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Move every line up one row and blank the last line
    function automatic void shift_screen_up();
        for (int k = 0; k < CELLS - COLUMNS; k++) begin
            screen_model[k] = screen_model[k + COLUMNS];
        end
        for (int k = CELLS - COLUMNS; k < CELLS; k++) begin
            screen_model[k] = BLANK_CELL;
        end
        row_model = ROW_W'(ROWS - 1);
        scroll_count++;
    endfunction

    // Apply one item to the screen model and return the result it yields
    function automatic term_result_t predict_terminal(term_item_t it);
        term_result_t r;
        r = '0;
        case (it.mode)
            MODE_PUT: begin
                // pending row scrolls before anything else
                if (row_model >= ROWS) begin
                    shift_screen_up();
                    r.scrolled = 1'b1;
                end
                if (it.code == NEWLINE_CODE) begin
                    row_model = row_model + 1'b1;
                    col_model = '0;
                    if (row_model == ROWS) begin
                        shift_screen_up();
                        r.scrolled = 1'b1;
                    end
                end else begin
                    r.w_index = IDX_W'(row_model * COLUMNS + col_model);
                    screen_model[r.w_index] = {attr_model, it.code};
                    r.wrote = 1'b1;
                    // wrap at end of line; last row leaves the row pending
                    if (col_model == COLUMNS - 1) begin
                        col_model = '0;
                        row_model = row_model + 1'b1;
                    end else begin
                        col_model = col_model + 1'b1;
                    end
                end
            end
            MODE_CLEAR: begin
                for (int k = 0; k < CELLS; k++) begin
                    screen_model[k] = BLANK_CELL;
                end
            end
            MODE_READ: begin
                if (it.idx < CELLS) begin
                    r.rdata = screen_model[it.idx];
                end
            end
            default: ;
        endcase
        r.row = row_model;
        r.col = col_model;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("MISMATCH %s: got 0x%0h expected 0x%0h (result %0d)",
                     what, got, want, result_count);
        end
    endtask

    // Queue one item and track the column the cursor will reach
    function automatic void add_item(logic [1:0] mode, logic [7:0] code, int idx);
        term_item_t it;
        it = '0;
        it.mode = mode;
        it.code = code;
        it.idx  = IDX_W'(idx);
        item_plan.push_back(it);
        if (mode == MODE_PUT) begin
            if (code == NEWLINE_CODE) begin
                gen_col = 0;
            end else begin
                gen_col = (gen_col == COLUMNS - 1) ? 0 : gen_col + 1;
            end
        end
    endfunction

    // Queue an attribute write that also sets the idle rate of the next phase
    function automatic void add_attr_write(logic [7:0] value, int gap_pct);
        term_item_t it;
        it = '0;
        it.is_cfg    = 1'b1;
        it.cfg_value = value;
        it.gap_pct   = 8'(gap_pct);
        item_plan.push_back(it);
    endfunction

    function automatic logic [7:0] rand_glyph();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == NEWLINE_CODE) begin
            c = CHAR_SPACE;
        end
        return c;
    endfunction

    function automatic int rand_cell_index();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return $urandom_range(CELLS, IDX_MAX);
        end else if (pick <= 4) begin
            return $urandom_range(CELLS - 2 * COLUMNS, CELLS - 1);
        end
        return $urandom_range(0, CELLS - 1);
    endfunction

    // Driver: hold each item on start until accepted, insert idle bursts,
    // and write the attribute only once the block has gone quiet
    always @(posedge i_clk) begin : drive_proc
        logic       n_start;
        logic       n_cfg_en;
        logic [7:0] n_cfg_data;
        n_start    = start;
        n_cfg_en   = 1'b0;
        n_cfg_data = i_cfg_wr_data;
        if (!i_rst_n) begin
            n_start  = 1'b0;
            gap_left = 0;
            idle_run = 0;
        end else begin
            if (start && !busy) begin
                cell_expect.push_back(predict_terminal(cur_item));
                items_sent++;
                case (cur_item.mode)
                    MODE_PUT:   put_count++;
                    MODE_READ:  read_count++;
                    MODE_CLEAR: clear_count++;
                    default: ;
                endcase
                n_start = 1'b0;
                if (gap_pct_now != 0 && $urandom_range(0, 99) < gap_pct_now) begin
                    gap_left = $urandom_range(1, 6);
                end
            end
            idle_run = (cell_expect.size() == 0 && !busy && !start) ? idle_run + 1 : 0;
            if (!n_start) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (item_plan.size() != 0) begin
                    if (item_plan[0].is_cfg) begin
                        if (idle_run >= SETTLE_CYCLES) begin
                            n_cfg_en    = 1'b1;
                            n_cfg_data  = item_plan[0].cfg_value;
                            attr_model  = item_plan[0].cfg_value;
                            gap_pct_now = item_plan[0].gap_pct;
                            void'(item_plan.pop_front());
                            idle_run = 0;
                        end
                    end else begin
                        cur_item = item_plan.pop_front();
                        n_start  = 1'b1;
                    end
                end
            end
        end
        start         <= n_start;
        i_cfg_wr_en   <= n_cfg_en;
        i_cfg_wr_data <= n_cfg_data;
        i_mode        <= cur_item.mode;
        i_char_code   <= cur_item.code;
        i_read_index  <= cur_item.idx;
    end

    // Monitor: compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin : check_proc
        term_result_t want;
        if (i_rst_n && o_strobe) begin
            result_count++;
            if (cell_expect.size() == 0) begin
                report_mismatch("result with no item waiting", 32'(o_cursor_row), 32'hFFFF_FFFF);
            end else begin
                want = cell_expect.pop_front();
                if (o_written_index !== want.w_index)
                    report_mismatch("written_index", 32'(o_written_index), 32'(want.w_index));
                if (o_wrote_cell !== want.wrote)
                    report_mismatch("wrote_cell", 32'(o_wrote_cell), 32'(want.wrote));
                if (o_scrolled !== want.scrolled)
                    report_mismatch("scrolled", 32'(o_scrolled), 32'(want.scrolled));
                if (o_cursor_row !== want.row)
                    report_mismatch("cursor_row", 32'(o_cursor_row), 32'(want.row));
                if (o_cursor_column !== want.col)
                    report_mismatch("cursor_column", 32'(o_cursor_column), 32'(want.col));
                if (o_read_data !== want.rdata)
                    report_mismatch("read_data", 32'(o_read_data), 32'(want.rdata));
            end
        end
    end

    // Watchdog: end the run after too many cycles with no traffic
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe || i_cfg_wr_en) begin
                stall_count = 0;
            end else begin
                stall_count++;
            end
            if (stall_count >= STALL_LIMIT) begin
                $display("Timeout: no traffic for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Plan the stimulus, release reset, wait for the drain, report
    initial begin : main_proc
        logic [7:0] phase_attr [RAND_PHASES];
        int         phase_gap [RAND_PHASES];
        int         target;
        int         pick;
        int         run_len;

        for (int k = 0; k < CELLS; k++) begin
            screen_model[k] = BLANK_CELL;
        end
        row_model      = '0;
        col_model      = '0;
        attr_model     = ATTR_RESET;
        cur_item       = '0;
        gap_pct_now    = 0;
        gen_col        = 0;
        mismatch_count = 0;
        items_sent     = 0;
        put_count      = 0;
        read_count     = 0;
        clear_count    = 0;
        scroll_count   = 0;
        result_count   = 0;
        stall_count    = 0;

        // Directed: blank reads, range edges, spare mode, char extremes,
        // newline, clear keeping the cursor, attribute extremes
        add_attr_write(ATTR_RESET, 20);
        add_item(MODE_READ, 8'h00, 0);
        add_item(MODE_READ, 8'h00, CELLS - 1);
        add_item(MODE_READ, 8'h00, CELLS);
        add_item(MODE_READ, 8'hFF, IDX_MAX);
        add_item(MODE_SPARE, 8'hFF, IDX_MAX);
        add_item(MODE_PUT, 8'h00, 0);
        add_item(MODE_PUT, 8'hFF, IDX_MAX);
        add_item(MODE_PUT, 8'h41, 0);
        add_item(MODE_PUT, NEWLINE_CODE, 0);
        add_item(MODE_PUT, CHAR_SPACE, 0);
        add_item(MODE_READ, 8'h00, 0);
        add_item(MODE_READ, 8'h00, 1);
        add_item(MODE_READ, 8'h00, COLUMNS);
        add_item(MODE_CLEAR, 8'h00, 0);
        add_item(MODE_READ, 8'h00, 1);
        add_attr_write(8'hFF, 20);
        add_item(MODE_PUT, 8'h5A, 0);
        add_item(MODE_READ, 8'h00, COLUMNS + 1);
        add_attr_write(8'h00, 20);
        add_item(MODE_PUT, 8'h7E, 0);
        add_item(MODE_READ, 8'h00, COLUMNS + 2);
        add_item(MODE_PUT, NEWLINE_CODE, 0);
        add_item(MODE_SPARE, 8'h00, 0);

        // Random phases: the cursor settles on the last row, so text runs
        // keep wrapping into the pending row and newlines keep scrolling
        phase_attr[0] = 8'($urandom_range(0, 255));
        phase_attr[1] = 8'hFF;
        phase_attr[2] = 8'h00;
        phase_attr[3] = 8'($urandom_range(0, 255));
        phase_attr[4] = 8'($urandom_range(0, 255));
        phase_gap[0]  = 0;
        phase_gap[1]  = 30;
        phase_gap[2]  = 40;
        phase_gap[3]  = 25;
        phase_gap[4]  = 0;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            add_attr_write(phase_attr[ph], phase_gap[ph]);
            target = item_plan.size() + ITEMS_PER_PHASE;
            while (item_plan.size() < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    // text run, often closed by a newline
                    run_len = $urandom_range(1, 100);
                    for (int k = 0; k < run_len; k++) begin
                        add_item(MODE_PUT, rand_glyph(), $urandom_range(0, IDX_MAX));
                    end
                    if ($urandom_range(0, 1) == 1) begin
                        add_item(MODE_PUT, NEWLINE_CODE, $urandom_range(0, IDX_MAX));
                    end
                end else if (pick < 60) begin
                    // fill the line exactly, then a newline or a char
                    run_len = COLUMNS - gen_col;
                    for (int k = 0; k < run_len; k++) begin
                        add_item(MODE_PUT, rand_glyph(), 0);
                    end
                    add_item(MODE_PUT, ($urandom_range(0, 1) == 1) ? NEWLINE_CODE : rand_glyph(),
                             0);
                end else if (pick < 72) begin
                    run_len = $urandom_range(1, 6);
                    for (int k = 0; k < run_len; k++) begin
                        add_item(MODE_READ, 8'($urandom_range(0, 255)), rand_cell_index());
                    end
                end else if (pick < 82) begin
                    run_len = $urandom_range(1, 3);
                    for (int k = 0; k < run_len; k++) begin
                        add_item(MODE_PUT, NEWLINE_CODE, $urandom_range(0, IDX_MAX));
                    end
                end else if (pick < 86) begin
                    add_item(MODE_CLEAR, 8'($urandom_range(0, 255)), $urandom_range(0, IDX_MAX));
                end else begin
                    // noise: any mode with any fields
                    add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             $urandom_range(0, IDX_MAX));
                end
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: sample after the edge so driver and monitor updates are settled
        while (item_plan.size() != 0 || start || cell_expect.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items: %0d puts, %0d reads, %0d clears, rest spare mode",
                 items_sent, put_count, read_count, clear_count);
        $display("Checked %0d results, %0d scrolls, %0d attribute settings",
                 result_count, scroll_count, RAND_PHASES + 3);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
